// ----- design/tmh_pkg.sv -----
// shared types, codes and deadline helpers for the timer heap
package tmh_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_KEY,
        S_TAIL,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_LD,
        S_DN_CMP,
        S_PLACE,
        S_ROOT_RD,
        S_ROOT_CHK
    } state_t;

    localparam logic [1:0] MODE_ARM    = 2'd0;
    localparam logic [1:0] MODE_ADJUST = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNARMED = 2'd2;

    localparam logic KIND_EXPIRED = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    typedef struct packed {
        logic [7:0]  key;
        logic [31:0] dl;
    } heap_ent_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  key;
        logic [1:0]  status;
        logic        pending;
        logic [15:0] remain;
        logic        last;
    } result_t;

    function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    function automatic logic [15:0] remain_ms(input logic [31:0] dl, input logic [31:0] now);
        logic [31:0] d;
        d = dl - now;
        if (d[31] || d == 32'd0)
            return 16'd0;
        else if (|d[31:16])
            return 16'hFFFF;
        else
            return d[15:0];
    endfunction

endpackage

// ----- design/tmh_ram.sv -----
// generic single write port ram with registered read
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- design/tmh_core.sv -----
// heap sequencer: key lookup, sift up and down, expiry and result requests
module tmh_core #(
    parameter int CAPACITY  = 32,
    parameter int KEY_COUNT = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       mode,
    input  logic [7:0]                       key,
    input  logic [15:0]                      timeout,
    output tmh_pkg::result_t                 res,
    input  logic                             out_free,
    output logic                             heap_we,
    output logic [$clog2(CAPACITY)-1:0]      heap_waddr,
    output tmh_pkg::heap_ent_t               heap_wdata,
    output logic                             heap_re,
    output logic [$clog2(CAPACITY)-1:0]      heap_raddr,
    input  tmh_pkg::heap_ent_t               heap_rdata,
    output logic                             pos_we,
    output logic [$clog2(KEY_COUNT)-1:0]     pos_waddr,
    output logic [$clog2(CAPACITY):0]        pos_wdata,
    output logic                             pos_re,
    output logic [$clog2(KEY_COUNT)-1:0]     pos_raddr,
    input  logic [$clog2(CAPACITY):0]        pos_rdata
);
    import tmh_pkg::*;

    localparam int PW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int KIW = $clog2(KEY_COUNT);

    state_t          state_reg, state_next;
    logic [1:0]      mode_reg, mode_next;
    logic [7:0]      key_reg, key_next;
    logic [15:0]     tout_reg, tout_next;
    logic [7:0]      ekey_reg, ekey_next;
    logic [31:0]     edl_reg, edl_next;
    logic [7:0]      lkey_reg, lkey_next;
    logic [31:0]     ldl_reg, ldl_next;
    logic [PW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [31:0]     time_reg, time_next;
    logic [1:0]      status_reg, status_next;
    logic            moved_reg, moved_next;
    logic [KIW-1:0]  clr_reg, clr_next;

    logic [8:0]      kred;
    logic [7:0]      kmod;
    logic            pos_armed;
    logic [PW-1:0]   pos_idx;
    logic [PW-1:0]   parent_idx;
    logic [PW:0]     child;
    logic [PW:0]     right;
    logic [PW:0]     cnt_ext;
    logic [CW-1:0]   tail;
    logic [PW-1:0]   tail_idx;
    logic [31:0]     dl_new;
    logic            full;
    logic            is_tick;
    logic            due;
    logic            up_swap;
    logic            right_win;
    logic [7:0]      best_key;
    logic [31:0]     best_dl;
    logic            dn_swap;

    always_comb
    begin
        kred = {1'b0, key};
        for (int s = 7; s >= 0; s--)
        begin
            if (32'(kred) >= (32'(KEY_COUNT) << s))
            begin
                kred = kred - 9'(32'(KEY_COUNT) << s);
            end
        end
    end

    assign kmod       = kred[7:0];
    assign pos_armed  = pos_rdata[PW];
    assign pos_idx    = pos_rdata[PW-1:0];
    assign parent_idx = PW'((idx_reg - PW'(1)) >> 1);
    assign child      = {idx_reg, 1'b1};
    assign right      = child + (PW+1)'(1);
    assign cnt_ext    = (PW+1)'(count_reg);
    assign tail       = count_reg - CW'(1);
    assign tail_idx   = PW'(tail);
    assign dl_new     = time_reg + 32'(tout_reg);
    assign full       = count_reg >= CW'(CAPACITY);
    assign is_tick    = mode_reg == MODE_TICK;
    assign due        = remain_ms(heap_rdata.dl, time_reg) == 16'd0;
    assign up_swap    = earlier(edl_reg, heap_rdata.dl);
    assign right_win  = (right < cnt_ext) && earlier(heap_rdata.dl, ldl_reg);
    assign best_key   = right_win ? heap_rdata.key : lkey_reg;
    assign best_dl    = right_win ? heap_rdata.dl : ldl_reg;
    assign dn_swap    = earlier(best_dl, edl_reg);
    assign in_ready   = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == KIW'(KEY_COUNT - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = (mode == MODE_TICK) ? S_ROOT_RD : S_KEY;
            end
            S_KEY:
            begin
                case (mode_reg)
                    MODE_ARM:
                        state_next = (pos_armed || !full) ? S_UP_RD : S_ROOT_RD;
                    MODE_ADJUST:
                        state_next = pos_armed ? S_UP_RD : S_ROOT_RD;
                    MODE_CANCEL:
                        state_next = (pos_armed && (CW'(pos_idx) < tail)) ? S_TAIL
                                                                            : S_ROOT_RD;
                    default:
                        state_next = S_ROOT_RD;
                endcase
            end
            S_TAIL:
                state_next = S_UP_RD;
            S_UP_RD:
            begin
                if (idx_reg != '0)
                    state_next = S_UP_CMP;
                else
                    state_next = moved_reg ? S_PLACE : S_DN_RD;
            end
            S_UP_CMP:
            begin
                if (up_swap)
                    state_next = S_UP_RD;
                else
                    state_next = moved_reg ? S_PLACE : S_DN_RD;
            end
            S_DN_RD:
                state_next = (child < cnt_ext) ? S_DN_LD : S_PLACE;
            S_DN_LD:
                state_next = S_DN_CMP;
            S_DN_CMP:
                state_next = dn_swap ? S_DN_RD : S_PLACE;
            S_PLACE:
                state_next = S_ROOT_RD;
            S_ROOT_RD:
            begin
                if (count_reg != '0)
                    state_next = S_ROOT_CHK;
                else if (out_free)
                    state_next = S_IDLE;
            end
            S_ROOT_CHK:
            begin
                if (out_free)
                begin
                    if (is_tick && due)
                        state_next = (tail != '0) ? S_TAIL : S_ROOT_RD;
                    else
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        key_next    = key_reg;
        tout_next   = tout_reg;
        ekey_next   = ekey_reg;
        edl_next    = edl_reg;
        lkey_next   = lkey_reg;
        ldl_next    = ldl_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        time_next   = time_reg;
        status_next = status_reg;
        moved_next  = moved_reg;
        clr_next    = clr_reg;
        heap_we     = 1'b0;
        heap_waddr  = idx_reg;
        heap_wdata  = heap_rdata;
        heap_re     = 1'b0;
        heap_raddr  = '0;
        pos_we      = 1'b0;
        pos_waddr   = KIW'(heap_rdata.key);
        pos_wdata   = {1'b1, idx_reg};
        pos_re      = 1'b0;
        pos_raddr   = KIW'(kmod);
        res         = '0;
        case (state_reg)
            S_CLEAR:
            begin
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = '0;
                clr_next  = clr_reg + KIW'(1);
            end
            S_IDLE:
            begin
                pos_re = 1'b1;
                if (in_valid)
                begin
                    mode_next   = mode;
                    key_next    = kmod;
                    tout_next   = timeout;
                    status_next = ST_OK;
                    if (mode == MODE_TICK)
                        time_next = time_reg + 32'd1;
                end
            end
            S_KEY:
            begin
                moved_next = 1'b0;
                case (mode_reg)
                    MODE_ARM:
                    begin
                        ekey_next = key_reg;
                        edl_next  = dl_new;
                        if (pos_armed)
                            idx_next = pos_idx;
                        else if (full)
                            status_next = ST_FULL;
                        else
                        begin
                            idx_next   = PW'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    MODE_ADJUST:
                    begin
                        ekey_next = key_reg;
                        edl_next  = dl_new;
                        idx_next  = pos_idx;
                        if (!pos_armed)
                            status_next = ST_UNARMED;
                    end
                    MODE_CANCEL:
                    begin
                        if (pos_armed)
                        begin
                            pos_we     = 1'b1;
                            pos_waddr  = KIW'(key_reg);
                            pos_wdata  = '0;
                            count_next = tail;
                            idx_next   = pos_idx;
                            heap_re    = 1'b1;
                            heap_raddr = tail_idx;
                        end
                        else
                            status_next = ST_UNARMED;
                    end
                    default:
                        status_next = ST_OK;
                endcase
            end
            S_TAIL:
            begin
                ekey_next  = heap_rdata.key;
                edl_next   = heap_rdata.dl;
                moved_next = 1'b0;
            end
            S_UP_RD:
            begin
                if (idx_reg != '0)
                begin
                    heap_re    = 1'b1;
                    heap_raddr = parent_idx;
                end
            end
            S_UP_CMP:
            begin
                if (up_swap)
                begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    idx_next   = parent_idx;
                    moved_next = 1'b1;
                end
            end
            S_DN_RD:
            begin
                if (child < cnt_ext)
                begin
                    heap_re    = 1'b1;
                    heap_raddr = PW'(child);
                end
            end
            S_DN_LD:
            begin
                lkey_next = heap_rdata.key;
                ldl_next  = heap_rdata.dl;
                if (right < cnt_ext)
                begin
                    heap_re    = 1'b1;
                    heap_raddr = PW'(right);
                end
            end
            S_DN_CMP:
            begin
                if (dn_swap)
                begin
                    heap_we         = 1'b1;
                    heap_wdata.key  = best_key;
                    heap_wdata.dl   = best_dl;
                    pos_we          = 1'b1;
                    pos_waddr       = KIW'(best_key);
                    idx_next        = right_win ? PW'(right) : PW'(child);
                end
            end
            S_PLACE:
            begin
                heap_we        = 1'b1;
                heap_wdata.key = ekey_reg;
                heap_wdata.dl  = edl_reg;
                pos_we         = 1'b1;
                pos_waddr      = KIW'(ekey_reg);
            end
            S_ROOT_RD:
            begin
                if (count_reg != '0)
                begin
                    heap_re    = 1'b1;
                    heap_raddr = '0;
                end
                else
                begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_DONE;
                    res.status = status_reg;
                    res.last   = 1'b1;
                end
            end
            S_ROOT_CHK:
            begin
                res.valid = 1'b1;
                if (is_tick && due)
                begin
                    res.kind = KIND_EXPIRED;
                    res.key  = heap_rdata.key;
                    if (out_free)
                    begin
                        pos_we     = 1'b1;
                        pos_wdata  = '0;
                        count_next = tail;
                        idx_next   = '0;
                        if (tail != '0)
                        begin
                            heap_re    = 1'b1;
                            heap_raddr = tail_idx;
                        end
                    end
                end
                else
                begin
                    res.kind    = KIND_DONE;
                    res.status  = status_reg;
                    res.pending = 1'b1;
                    res.remain  = remain_ms(heap_rdata.dl, time_reg);
                    res.last    = 1'b1;
                end
            end
            default:
                status_next = status_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            count_reg  <= '0;
            time_reg   <= '0;
            clr_reg    <= '0;
            moved_reg  <= 1'b0;
            status_reg <= ST_OK;
            mode_reg   <= MODE_ARM;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            time_reg   <= time_next;
            clr_reg    <= clr_next;
            moved_reg  <= moved_next;
            status_reg <= status_next;
            mode_reg   <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        tout_reg <= tout_next;
        ekey_reg <= ekey_next;
        edl_reg  <= edl_next;
        lkey_reg <= lkey_next;
        ldl_reg  <= ldl_next;
        idx_reg  <= idx_next;
    end
endmodule

// ----- design/timer_min_heap.sv -----
// top level: keyed timer heap with heap and key position memories and result register
//
//  channel  signals                                        direction
//  request  in_valid in_ready mode key timeout             in
//  result   out_valid out_ready kind expired_key status    out
//           has_pending next_remaining last
//
// after reset a clearing pass writes every entry of the key position memory to unarmed
// a request that moves an entry sifts it up by parent compares, else down by child compares;
// a tick removes each expired key at the root and sifts the tail entry down from the root
// all heap reads go through the single read port of the heap memory
// a result waits in the output register; the sequencer holds while it is not taken
module timer_min_heap #(
    parameter int CAPACITY  = 32,
    parameter int KEY_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  key,
    input  logic [15:0] timeout,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  expired_key,
    output logic [1:0]  status,
    output logic        has_pending,
    output logic [15:0] next_remaining,
    output logic        last
);
    import tmh_pkg::*;

    localparam int PW  = $clog2(CAPACITY);
    localparam int KIW = $clog2(KEY_COUNT);

    result_t         res;
    logic            out_free;
    logic            heap_we, heap_re, pos_we, pos_re;
    logic [PW-1:0]   heap_waddr, heap_raddr;
    heap_ent_t       heap_wdata, heap_rdata;
    logic [KIW-1:0]  pos_waddr, pos_raddr;
    logic [PW:0]     pos_wdata, pos_rdata;

    logic            out_valid_reg, out_valid_next;
    result_t         out_reg, out_next;

    tmh_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(CAPACITY)) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .re    (heap_re),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    tmh_ram #(.WIDTH(PW + 1), .DEPTH(KEY_COUNT)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    tmh_core #(.CAPACITY(CAPACITY), .KEY_COUNT(KEY_COUNT)) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .key        (key),
        .timeout    (timeout),
        .res        (res),
        .out_free   (out_free),
        .heap_we    (heap_we),
        .heap_waddr (heap_waddr),
        .heap_wdata (heap_wdata),
        .heap_re    (heap_re),
        .heap_raddr (heap_raddr),
        .heap_rdata (heap_rdata),
        .pos_we     (pos_we),
        .pos_waddr  (pos_waddr),
        .pos_wdata  (pos_wdata),
        .pos_re     (pos_re),
        .pos_raddr  (pos_raddr),
        .pos_rdata  (pos_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free)
        begin
            out_valid_next = res.valid;
            if (res.valid)
                out_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign expired_key    = out_reg.key;
    assign status         = out_reg.status;
    assign has_pending    = out_reg.pending;
    assign next_remaining = out_reg.remain;
    assign last           = out_reg.last;
endmodule

// ----- sim/tb.sv -----
// testbench for timer_min_heap: random and directed requests checked against a heap predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmh_pkg::*;

    localparam int CAP = 32;
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  key;
        logic [15:0] timeout;
    } request_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  expired_key;
        logic [1:0]  status;
        logic        has_pending;
        logic [15:0] next_remaining;
        logic        last;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [7:0]  key;
    logic [15:0] timeout;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [7:0]  expired_key;
    logic [1:0]  status;
    logic        has_pending;
    logic [15:0] next_remaining;
    logic        last;

    timer_min_heap uut (.*);

    request_t pending_requests[$];
    outcome_t expected_outcomes[$];

    logic [7:0]  hk[CAP];
    logic [31:0] hd[CAP];
    logic [4:0]  kpos[256];
    logic        karmed[256];
    int          hcount;
    logic [31:0] now_ms;

    int  failures;
    int  in_wait;
    int  out_wait;
    int  idle_cycles;

    function automatic bit is_earlier(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic void place(int p, logic [7:0] k, logic [31:0] dl);
        hk[p] = k;
        hd[p] = dl;
        kpos[k] = p[4:0];
    endfunction

    function automatic void swap_entries(int a, int b);
        logic [7:0]  ka;
        logic [31:0] da;
        ka = hk[a];
        da = hd[a];
        place(a, hk[b], hd[b]);
        place(b, ka, da);
    endfunction

    function automatic bit sift_up(int i);
        bit moved;
        int p;
        moved = 0;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!is_earlier(hd[i], hd[p]))
                break;
            swap_entries(i, p);
            i = p;
            moved = 1;
        end
        return moved;
    endfunction

    function automatic void sift_down(int i);
        int c;
        forever begin
            c = 2 * i + 1;
            if (c >= hcount)
                break;
            if (c + 1 < hcount && is_earlier(hd[c + 1], hd[c]))
                c++;
            if (!is_earlier(hd[c], hd[i]))
                break;
            swap_entries(i, c);
            i = c;
        end
    endfunction

    function automatic void reorder(int i);
        if (!sift_up(i))
            sift_down(i);
    endfunction

    function automatic void remove_entry(int i);
        int tail;
        tail = hcount - 1;
        karmed[hk[i]] = 0;
        if (i < tail) begin
            place(i, hk[tail], hd[tail]);
            hcount = tail;
            reorder(i);
        end
        else
            hcount = tail;
    endfunction

    function automatic logic [15:0] time_to_next();
        logic [31:0] d;
        if (hcount == 0)
            return 16'd0;
        d = hd[0] - now_ms;
        if (d[31] || d == 0)
            return 16'd0;
        return (d > 32'hFFFF) ? 16'hFFFF : d[15:0];
    endfunction

    function automatic void predict_timer_op(request_t r);
        logic [1:0]  st;
        logic [31:0] d;
        outcome_t    o;
        st = ST_OK;
        case (r.mode)
            MODE_ARM: begin
                if (karmed[r.key]) begin
                    hd[kpos[r.key]] = now_ms + r.timeout;
                    reorder(kpos[r.key]);
                end
                else if (hcount >= CAP)
                    st = ST_FULL;
                else begin
                    place(hcount, r.key, now_ms + r.timeout);
                    karmed[r.key] = 1;
                    hcount++;
                    void'(sift_up(hcount - 1));
                end
            end
            MODE_ADJUST: begin
                if (!karmed[r.key])
                    st = ST_UNARMED;
                else begin
                    hd[kpos[r.key]] = now_ms + r.timeout;
                    reorder(kpos[r.key]);
                end
            end
            MODE_CANCEL: begin
                if (!karmed[r.key])
                    st = ST_UNARMED;
                else
                    remove_entry(kpos[r.key]);
            end
            default: begin
                now_ms++;
                while (hcount > 0) begin
                    d = hd[0] - now_ms;
                    if (d != 0 && !d[31])
                        break;
                    o = '{KIND_EXPIRED, hk[0], ST_OK, 1'b0, 16'd0, 1'b0};
                    expected_outcomes = {expected_outcomes, o};
                    remove_entry(0);
                end
            end
        endcase
        o = '{KIND_DONE, 8'd0, st, hcount > 0, time_to_next(), 1'b1};
        expected_outcomes = {expected_outcomes, o};
    endfunction

    function automatic void add_request(logic [1:0] m, logic [7:0] k, logic [15:0] t);
        request_t r;
        r = '{m, k, t};
        pending_requests = {pending_requests, r};
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 0;
            mode <= '0;
            key <= '0;
            timeout <= '0;
            in_wait <= $urandom_range(0, 17);
        end
        else begin
            if (in_valid && in_ready)
                predict_timer_op(pending_requests.pop_front());
            if (!in_valid || in_ready) begin
                if (pending_requests.size() > 0 && in_wait == 0) begin
                    in_valid <= 1;
                    mode <= pending_requests[0].mode;
                    key <= pending_requests[0].key;
                    timeout <= pending_requests[0].timeout;
                    in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                end
                else begin
                    in_valid <= 0;
                    if (in_wait > 0)
                        in_wait <= in_wait - 1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 0;
            out_wait <= $urandom_range(0, 17);
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0
                           : idle_cycles + 1;
            if (out_valid && out_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected result kind %0d key %0d", kind, expired_key);
                    failures++;
                end
                else begin
                    outcome_t e;
                    e = expected_outcomes.pop_front();
                    if (kind !== e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, kind); failures++;
                    end
                    if (expired_key !== e.expired_key) begin
                        $error("expired_key exp %0d got %0d", e.expired_key, expired_key);
                        failures++;
                    end
                    if (status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, status); failures++;
                    end
                    if (has_pending !== e.has_pending) begin
                        $error("has_pending exp %0d got %0d", e.has_pending, has_pending);
                        failures++;
                    end
                    if (next_remaining !== e.next_remaining) begin
                        $error("next_remaining exp %0d got %0d", e.next_remaining,
                               next_remaining);
                        failures++;
                    end
                    if (last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, last); failures++;
                    end
                end
            end
            if (out_wait > 0) begin
                out_ready <= 0;
                out_wait <= out_wait - 1;
            end
            else begin
                out_ready <= 1;
                if (out_valid)
                    out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int r;
        failures = 0;
        for (int i = 0; i < 256; i++)
            karmed[i] = 0;
        hcount = 0;
        now_ms = 0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;

        // directed
        add_request(MODE_TICK, 8'd0, 16'd0);
        add_request(MODE_ADJUST, 8'd5, 16'd3);
        add_request(MODE_CANCEL, 8'd5, 16'd3);
        add_request(MODE_ARM, 8'd0, 16'd0);
        add_request(MODE_ARM, 8'd255, 16'hFFFF);
        add_request(MODE_ARM, 8'd1, 16'd2);
        add_request(MODE_ARM, 8'd2, 16'd2);
        add_request(MODE_ARM, 8'd3, 16'd2);
        add_request(MODE_ARM, 8'd1, 16'd4);
        add_request(MODE_ADJUST, 8'd3, 16'd1);
        add_request(MODE_ADJUST, 8'd255, 16'd5);
        add_request(MODE_TICK, 8'hAA, 16'hFFFF);
        add_request(MODE_TICK, 8'd0, 16'd0);
        add_request(MODE_CANCEL, 8'd1, 16'd0);
        add_request(MODE_CANCEL, 8'd1, 16'd0);
        for (int i = 0; i < 6; i++)
            add_request(MODE_TICK, 8'd0, 16'd0);
        // fill to capacity, then one refused arm
        for (int i = 0; i < CAP + 1; i++)
            add_request(MODE_ARM, 8'(16 + i), 16'($urandom_range(1, 40)));
        for (int i = 0; i < 45; i++)
            add_request(MODE_TICK, 8'd0, 16'd0);

        // random
        n = 0;
        while (n < 200) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                add_request(MODE_ARM, 8'($urandom_range(0, 47) | ($urandom_range(0, 9) == 0
                            ? $urandom_range(0, 255) : 0)),
                            ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                            16'($urandom_range(0, 30)));
            else if (r < 55)
                add_request(MODE_ADJUST, 8'($urandom_range(0, 63)),
                            ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                            16'($urandom_range(0, 30)));
            else if (r < 65)
                add_request(MODE_CANCEL, ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                            8'($urandom_range(0, 63)), 16'($urandom));
            else
                add_request(MODE_TICK, 8'($urandom), 16'($urandom));
            n++;
        end

        wait (pending_requests.size() == 0 && expected_outcomes.size() == 0);
        repeat (200) @(posedge clk);
        if (failures == 0 && expected_outcomes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ----- files.f -----
design/tmh_pkg.sv
design/tmh_ram.sv
design/tmh_core.sv
design/timer_min_heap.sv
sim/tb.sv
